// ===== rtl/rope_pkg.sv =====
// ----------------------------------------------------------------------------
// rope_pkg
// Types and constants shared by the rotary position embedding block.
// ----------------------------------------------------------------------------
package rope_pkg;

   localparam int DATA_BITS      = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int INDEX_BITS     = 8;
   localparam int POS_BITS       = 8;
   localparam int TBL_ADDR_BITS  = 16;
   localparam int TBL_DEPTH      = 1 << TBL_ADDR_BITS;
   localparam int PEND_DEPTH     = 128;
   localparam int PEND_ADDR_BITS = $clog2(PEND_DEPTH);
   localparam int DIM_BITS       = 9;
   localparam int DIM_SEL_BITS   = 3;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = DIM_SEL_BITS;

   // product and rounding widths
   localparam int PROD_BITS  = 2 * DATA_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int SHIFT_BITS = SUM_BITS - COEF_FRAC_BITS;

   // result queue, counted in pairs
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_TABLE_WRITE = 1'b0;
   localparam logic CMD_ELEMENT     = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_SELECT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEOX_MODE  = 1'd1;

   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_32  = 3'd0;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_64  = 3'd1;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_96  = 3'd2;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_128 = 3'd3;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_RESET = DIM_SEL_128;

   typedef struct packed {
      logic                        command;
      logic [TBL_ADDR_BITS-1:0]    table_index;
      logic [POS_BITS-1:0]         position;
      logic signed [DATA_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]       element_index;
      logic signed [DATA_BITS-1:0] out_value;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic                     en;
      logic [TBL_ADDR_BITS-1:0] cos_addr;
      logic [TBL_ADDR_BITS-1:0] sin_addr;
   } tbl_rd_type;

   typedef struct packed {
      logic                        valid;
      logic [INDEX_BITS-1:0]       lo_idx;
      logic [INDEX_BITS-1:0]       hi_idx;
      logic                        last;
      logic signed [DATA_BITS-1:0] x1;
   } stage_type;

   typedef struct packed {
      logic    valid;
      rsp_type lo;
      rsp_type hi;
   } pair_type;

endpackage

// ===== rtl/rope_table.sv =====
// ----------------------------------------------------------------------------
// rope_table
// Cos/sin coefficient memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rope_table (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [rope_pkg::TBL_ADDR_BITS-1:0]    wr_addr,
   input  logic signed [rope_pkg::DATA_BITS-1:0] wr_data,
   input  rope_pkg::tbl_rd_type                  rd,
   output logic signed [rope_pkg::DATA_BITS-1:0] cos_ff,
   output logic signed [rope_pkg::DATA_BITS-1:0] sin_ff
);
   import rope_pkg::*;

   logic signed [DATA_BITS-1:0] tbl_mem [TBL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      if (rd.en) begin
         cos_ff <= tbl_mem[rd.cos_addr];
         sin_ff <= tbl_mem[rd.sin_addr];
      end
   end

endmodule

// ===== rtl/rope_front.sv =====
// ----------------------------------------------------------------------------
// rope_front
// Config registers, element counter, head position, pair buffer and
// coefficient address generation.
// ----------------------------------------------------------------------------
module rope_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rope_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rope_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  accept,
   input  rope_pkg::req_type                     req_data,
   output rope_pkg::tbl_rd_type                  tbl_rd,
   output rope_pkg::stage_type                   s1_ff,
   output logic signed [rope_pkg::DATA_BITS-1:0] x0_ff
);
   import rope_pkg::*;

   logic [DIM_SEL_BITS-1:0] dim_select_ff;
   logic                    neox_ff;
   logic [INDEX_BITS-1:0]   count_ff, count_in;
   logic [POS_BITS-1:0]     head_pos_ff, head_pos_in;
   stage_type               s1_in;

   logic signed [DATA_BITS-1:0] pend_mem [PEND_DEPTH];

   logic [DIM_BITS-1:0]      dim, dim_m1, nxt;
   logic [INDEX_BITS-1:0]    half, cur, col, lo_idx;
   logic [PEND_ADDR_BITS-1:0] pend_waddr;
   logic                     elem, is_pair, pend_wr;
   logic [TBL_ADDR_BITS:0]   base, cos_sum, sin_sum;

   function automatic logic [DIM_BITS-1:0] dim_of(input logic [DIM_SEL_BITS-1:0] sel);
      logic [DIM_BITS-1:0] d;
      unique case (sel)
         DIM_SEL_32:  d = 9'd32;
         DIM_SEL_64:  d = 9'd64;
         DIM_SEL_96:  d = 9'd96;
         DIM_SEL_128: d = 9'd128;
         default:     d = 9'd256;
      endcase
      return d;
   endfunction

   always_comb begin
      elem   = accept && (req_data.command == CMD_ELEMENT);
      dim    = dim_of(dim_select_ff);
      dim_m1 = dim - 9'd1;
      half   = dim[DIM_BITS-1:1];
      // a shrunk dimension restarts the head
      cur    = ({1'b0, count_ff} >= dim) ? '0 : count_ff;
      head_pos_in = (cur == '0) ? req_data.position : head_pos_ff;

      if (neox_ff) begin
         is_pair    = (cur >= half);
         col        = cur - half;
         lo_idx     = col;
         pend_waddr = cur[PEND_ADDR_BITS-1:0];
      end else begin
         is_pair    = cur[0];
         col        = {1'b0, cur[INDEX_BITS-1:1]};
         lo_idx     = cur - 8'd1;
         pend_waddr = col[PEND_ADDR_BITS-1:0];
      end
      pend_wr = elem && !is_pair;

      base    = (TBL_ADDR_BITS+1)'(head_pos_in) * (TBL_ADDR_BITS+1)'(dim);
      cos_sum = base + (TBL_ADDR_BITS+1)'(col);
      sin_sum = cos_sum + (TBL_ADDR_BITS+1)'(half);

      tbl_rd.en       = elem && is_pair;
      tbl_rd.cos_addr = cos_sum[TBL_ADDR_BITS-1:0];
      tbl_rd.sin_addr = sin_sum[TBL_ADDR_BITS-1:0];

      nxt      = {1'b0, cur} + 9'd1;
      count_in = (nxt == dim) ? '0 : nxt[INDEX_BITS-1:0];

      s1_in.valid  = elem && is_pair;
      s1_in.lo_idx = lo_idx;
      s1_in.hi_idx = cur;
      s1_in.last   = ({1'b0, cur} == dim_m1);
      s1_in.x1     = req_data.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_select_ff <= DIM_SEL_RESET;
         neox_ff       <= 1'b1;
         count_ff      <= '0;
         head_pos_ff   <= '0;
         s1_ff.valid   <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_DIM_SELECT) begin
            dim_select_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_NEOX_MODE) begin
            neox_ff <= csr_wdata[0];
         end
         if (elem) begin
            count_ff    <= count_in;
            head_pos_ff <= head_pos_in;
         end
         s1_ff.valid <= s1_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff.lo_idx <= s1_in.lo_idx;
      s1_ff.hi_idx <= s1_in.hi_idx;
      s1_ff.last   <= s1_in.last;
      s1_ff.x1     <= s1_in.x1;
   end

   // write and read of one entry never fall on the same item
   always_ff @(posedge clock) begin
      if (pend_wr) begin
         pend_mem[pend_waddr] <= req_data.value;
      end
      if (s1_in.valid) begin
         x0_ff <= pend_mem[col[PEND_ADDR_BITS-1:0]];
      end
   end

endmodule

// ===== rtl/rope_rotate.sv =====
// ----------------------------------------------------------------------------
// rope_rotate
// Pair rotation: registered products, then add, round half up, saturate.
// ----------------------------------------------------------------------------
module rope_rotate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rope_pkg::stage_type                   s1,
   input  logic signed [rope_pkg::DATA_BITS-1:0] x0,
   input  logic signed [rope_pkg::DATA_BITS-1:0] cos_c,
   input  logic signed [rope_pkg::DATA_BITS-1:0] sin_c,
   output rope_pkg::pair_type                    push
);
   import rope_pkg::*;

   logic                        v2_ff;
   logic [INDEX_BITS-1:0]       lo_idx2_ff, hi_idx2_ff;
   logic                        last2_ff;
   logic signed [PROD_BITS-1:0] x0c_ff, x1s_ff, x1c_ff, x0s_ff;

   function automatic logic signed [DATA_BITS-1:0] round_sat(
      input logic signed [SUM_BITS-1:0] sum);
      logic signed [SUM_BITS-1:0]   rnd;
      logic signed [SHIFT_BITS-1:0] q;
      logic signed [DATA_BITS-1:0]  r;
      rnd = sum + SUM_BITS'(1 << (COEF_FRAC_BITS - 1));
      q   = $signed(rnd[SUM_BITS-1:COEF_FRAC_BITS]);
      if (q > $signed(SHIFT_BITS'((1 << (DATA_BITS - 1)) - 1))) begin
         r = {1'b0, {(DATA_BITS-1){1'b1}}};
      end else if (q < -$signed(SHIFT_BITS'(1 << (DATA_BITS - 1)))) begin
         r = {1'b1, {(DATA_BITS-1){1'b0}}};
      end else begin
         r = q[DATA_BITS-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= s1.valid;
      end
   end

   always_ff @(posedge clock) begin
      lo_idx2_ff <= s1.lo_idx;
      hi_idx2_ff <= s1.hi_idx;
      last2_ff   <= s1.last;
      x0c_ff     <= x0 * cos_c;
      x1s_ff     <= s1.x1 * sin_c;
      x1c_ff     <= s1.x1 * cos_c;
      x0s_ff     <= x0 * sin_c;
   end

   always_comb begin
      push.valid            = v2_ff;
      push.lo.element_index = lo_idx2_ff;
      push.lo.out_value     = round_sat(SUM_BITS'(x0c_ff) - SUM_BITS'(x1s_ff));
      push.lo.last          = 1'b0;
      push.hi.element_index = hi_idx2_ff;
      push.hi.out_value     = round_sat(SUM_BITS'(x1c_ff) + SUM_BITS'(x0s_ff));
      push.hi.last          = last2_ff;
   end

endmodule

// ===== rtl/rope_outq.sv =====
// ----------------------------------------------------------------------------
// rope_outq
// Result queue of rotated pairs with credit count; sends low then high item.
// ----------------------------------------------------------------------------
module rope_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic               reserve,
   input  rope_pkg::pair_type push,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rope_pkg::rsp_type  rsp_data
);
   import rope_pkg::*;

   rsp_type lo_mem [QUEUE_DEPTH];
   rsp_type hi_mem [QUEUE_DEPTH];

   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] fill_ff, fill_in, credit_ff, credit_in;
   logic                 sel_ff, pop_half, pop_pair;

   always_comb begin
      rsp_valid = (fill_ff != '0);
      rsp_data  = sel_ff ? hi_mem[rd_ptr_ff] : lo_mem[rd_ptr_ff];
      pop_half  = rsp_valid && !rsp_stall;
      pop_pair  = pop_half && sel_ff;
      full      = (credit_ff == QCNT_BITS'(QUEUE_DEPTH));

      case ({push.valid, pop_pair})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
      // credit covers pairs still in the pipe plus pairs queued
      case ({reserve, pop_pair})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
         sel_ff    <= 1'b0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_pair) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (pop_half) begin
            sel_ff <= !sel_ff;
         end
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         lo_mem[wr_ptr_ff] <= push.lo;
         hi_mem[wr_ptr_ff] <= push.hi;
      end
   end

endmodule

// ===== rtl/rotary_position_embedding.sv =====
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotary position embedding over head vectors streamed one element per item.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low. A table-write item stores
// one Q1.14 word in the 64K-word cos/sin memory; an element item advances the
// head counter and either parks the element in the 128-entry pair buffer or
// completes a pair. A completed pair reads cos and sin from the two read ports
// of the table memory and its partner from the pair buffer in the cycle it is
// accepted, multiplies in the next, and then rounds (half up), saturates and
// queues both rotated items from the product registers. The queue holds four
// pairs and sends the lower index first, one item per cycle while rsp_stall is
// low, so each pair leaves as two items. req_stall rises when every queue slot
// is promised to a pair already accepted; in half-split mode the second half
// of a head produces two items per input item, so once the queue has filled
// the input is held back to the pace of the output.
// Table memory and pair buffer come up with undefined contents.
// ----------------------------------------------------------------------------
module rotary_position_embedding (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rope_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rope_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [rope_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rope_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rope_pkg::*;

   logic                        accept, tbl_wr, full;
   tbl_rd_type                  tbl_rd;
   stage_type                   s1;
   logic signed [DATA_BITS-1:0] x0, cos_c, sin_c;
   pair_type                    push;

   // stall only when the result queue has no free pair slot
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign tbl_wr    = accept && (req_data.command == CMD_TABLE_WRITE);

   rope_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .tbl_rd    (tbl_rd),
      .s1_ff     (s1),
      .x0_ff     (x0)
   );

   rope_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_data.table_index),
      .wr_data (req_data.value),
      .rd      (tbl_rd),
      .cos_ff  (cos_c),
      .sin_ff  (sin_c)
   );

   rope_rotate u_rotate (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .x0    (x0),
      .cos_c (cos_c),
      .sin_c (sin_c),
      .push  (push)
   );

   // a pair's slot is reserved at accept, freed when its high item leaves
   rope_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .reserve   (tbl_rd.en),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/rotary_position_embedding_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_tb
// Self-checking regression for the rotary position embedding block.
// ----------------------------------------------------------------------------
// Streams cos/sin table words and head elements into the block and keeps a
// cycle-free prediction of every rotated element. Each accepted result is
// compared field by field with the oldest prediction. Both handshake sides
// idle and stall at random. Configuration changes only with the block
// drained. Table words are written before any element pair can read them.
// ----------------------------------------------------------------------------
module rotary_position_embedding_tb;
   import rope_pkg::*;

   localparam int MAX_DIM      = 256;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_LIMIT = 10;

   // dim_select codes not named in the package
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_256      = 3'd4;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_UNUSED_5 = 3'd5;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_UNUSED_6 = 3'd6;
   localparam logic [DIM_SEL_BITS-1:0] DIM_SEL_UNUSED_7 = 3'd7;

   // neox_mode register values
   localparam logic [CSR_DATA_BITS-1:0] MODE_INTERLEAVED = 3'd0;
   localparam logic [CSR_DATA_BITS-1:0] MODE_HALF_SPLIT  = 3'd1;

   localparam longint SAT_MAX = (longint'(1) <<< (DATA_BITS - 1)) - 1;
   localparam longint SAT_MIN = -SAT_MAX - 1;

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   rotary_position_embedding uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop if the block hangs
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Rotation predictor: own copy of table, pair buffer and head state
   // ---------------------------------------------------------------------
   logic signed [DATA_BITS-1:0] coef_word [0:TBL_DEPTH-1];
   bit                          coef_known [0:TBL_DEPTH-1];
   logic signed [DATA_BITS-1:0] half_buf [0:PEND_DEPTH-1];
   int unsigned                 elem_cnt = 0;
   logic [POS_BITS-1:0]         head_pos = '0;
   logic [DIM_SEL_BITS-1:0]     cfg_dim_sel = DIM_SEL_RESET;
   bit                          cfg_neox = 1'b1;

   // rotated elements still owed by the block, oldest first
   rsp_type due_rotations [$];

   // bookkeeping
   int unsigned fail_count = 0;
   int unsigned results_checked = 0;
   int unsigned elements_sent = 0;
   int unsigned writes_sent = 0;
   int unsigned configs_run = 0;
   int unsigned input_held = 0;

   // traffic shaping knobs, flipped per test
   bit          gaps_enable = 1'b1;
   bit          stall_enable = 1'b1;
   bit          noise_writes = 1'b0;
   int unsigned hold_cycles = 0;

   int unsigned row_pool [8] = '{0, 1, 2, 3, 127, 128, 254, 255};

   function automatic int unsigned head_dim(input logic [DIM_SEL_BITS-1:0] sel);
      case (sel)
         DIM_SEL_32:  return 32;
         DIM_SEL_64:  return 64;
         DIM_SEL_96:  return 96;
         DIM_SEL_128: return 128;
         default:     return MAX_DIM;
      endcase
   endfunction

   // round half up off the Q1.14 coefficient's 14 fraction bits, then clamp
   function automatic logic signed [DATA_BITS-1:0] rotate_term(
      input logic signed [DATA_BITS-1:0] a,
      input logic signed [DATA_BITS-1:0] c,
      input logic signed [DATA_BITS-1:0] b,
      input logic signed [DATA_BITS-1:0] s,
      input bit                          subtract);
      longint acc;
      longint term_b;
      acc = longint'(a) * longint'(c);
      term_b = longint'(b) * longint'(s);
      acc = subtract ? acc - term_b : acc + term_b;
      acc = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (acc > SAT_MAX) acc = SAT_MAX;
      if (acc < SAT_MIN) acc = SAT_MIN;
      return acc[DATA_BITS-1:0];
   endfunction

   // Where does this element land, and does it close a pair? Pure lookup.
   function automatic bit locate_pair(input req_type item, output int unsigned slot,
                                      output int unsigned col, output int unsigned cos_at,
                                      output int unsigned sin_at);
      int unsigned dim;
      int unsigned half;
      int unsigned row;
      dim = head_dim(cfg_dim_sel);
      half = dim / 2;
      // a shrunk dimension can leave the count past the end: new head
      slot = (elem_cnt >= dim) ? 0 : elem_cnt;
      row = (slot == 0) ? item.position : head_pos;
      col = cfg_neox ? ((slot < half) ? slot : slot - half) : slot / 2;
      cos_at = row * dim + col;
      sin_at = cos_at + half;
      return cfg_neox ? (slot >= half) : (slot % 2 == 1);
   endfunction

   function automatic void rotate_element(input req_type item);
      int unsigned slot;
      int unsigned col;
      int unsigned cos_at;
      int unsigned sin_at;
      int unsigned dim;
      logic signed [DATA_BITS-1:0] x0;
      rsp_type lo;
      rsp_type hi;
      dim = head_dim(cfg_dim_sel);
      if (locate_pair(item, slot, col, cos_at, sin_at)) begin
         x0 = half_buf[col];
         lo.element_index = cfg_neox ? col : slot - 1;
         lo.out_value = rotate_term(x0, coef_word[cos_at], item.value,
                                    coef_word[sin_at], 1'b1);
         lo.last = 1'b0;
         hi.element_index = slot;
         hi.out_value = rotate_term(item.value, coef_word[cos_at], x0,
                                    coef_word[sin_at], 1'b0);
         hi.last = (slot == dim - 1);
         due_rotations.push_back(lo);
         due_rotations.push_back(hi);
      end else begin
         half_buf[col] = item.value;
      end
      if (slot == 0) head_pos = item.position;
      elem_cnt = (slot + 1 >= dim) ? 0 : slot + 1;
   endfunction

   function automatic void apply_item(input req_type item);
      if (item.command == CMD_TABLE_WRITE) begin
         coef_word[item.table_index] = item.value;
         coef_known[item.table_index] = 1'b1;
      end else begin
         rotate_element(item);
      end
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   // mostly short, now and then a long one
   function automatic int unsigned random_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [DATA_BITS-1:0] corner_value(input int unsigned k);
      case (k % 8)
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'sh0001;
         4: return 16'shFFFF;
         5: return 16'sh2000;   // one half in Q1.14: rounding ties
         6: return 16'shE000;
         default: return 16'sh4000;
      endcase
   endfunction

   function automatic logic signed [DATA_BITS-1:0] pick_value();
      if ($urandom_range(0, 7) == 0) return corner_value($urandom_range(0, 7));
      return $urandom;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random stalls plus an on-demand long hold-off
   // ---------------------------------------------------------------------
   initial begin
      int unsigned burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_enable && $urandom_range(0, 3) == 0) burst = random_gap();
         end
      end
   end

   // Result checker: every accepted item against the oldest prediction
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_checked++;
            if (due_rotations.size() == 0) begin
               note_failure($sformatf("unexpected result: idx %0d value %0d last %0b",
                  rsp_data.element_index, rsp_data.out_value, rsp_data.last));
            end else begin
               want = due_rotations.pop_front();
               if (rsp_data.element_index !== want.element_index ||
                   rsp_data.out_value !== want.out_value ||
                   rsp_data.last !== want.last) begin
                  note_failure($sformatf(
                     "mismatch: expected idx %0d value %0d last %0b, got idx %0d value %0d last %0b",
                     want.element_index, want.out_value, want.last,
                     rsp_data.element_index, rsp_data.out_value, rsp_data.last));
               end
            end
         end
      end
   end

   // count cycles where the block pushed back on the input
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_held++;
   end

   // ---------------------------------------------------------------------
   // Input side. Every task here starts and ends at a falling edge with
   // no pending assignment to the request signals in that time step.
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      apply_item(item);
      @(negedge clock);
      gap = (gaps_enable && $urandom_range(0, 2) == 0) ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_table_write(input int unsigned addr,
                                   input logic signed [DATA_BITS-1:0] value);
      req_type item;
      item.command = CMD_TABLE_WRITE;
      item.table_index = addr;
      item.position = $urandom;   // don't-care on writes
      item.value = value;
      send_item(item);
      writes_sent++;
   endtask

   // Table words a pair is about to read get written first if still unknown.
   task automatic send_element(input logic [POS_BITS-1:0] position,
                               input logic signed [DATA_BITS-1:0] value);
      req_type item;
      int unsigned slot;
      int unsigned col;
      int unsigned cos_at;
      int unsigned sin_at;
      item.command = CMD_ELEMENT;
      item.table_index = $urandom;   // don't-care on elements
      item.position = position;
      item.value = value;
      if (locate_pair(item, slot, col, cos_at, sin_at)) begin
         if (!coef_known[cos_at]) send_table_write(cos_at, pick_value());
         if (!coef_known[sin_at]) send_table_write(sin_at, pick_value());
      end
      send_item(item);
      elements_sent++;
   endtask

   // Position matters only on the first element; the rest carry noise.
   task automatic send_head(input logic [POS_BITS-1:0] position, input int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
         if (noise_writes && $urandom_range(0, 15) == 0)
            send_table_write($urandom_range(0, TBL_DEPTH - 1), pick_value());
         send_element((k == 0) ? position : logic'($urandom_range(0, 1)) ?
                      position : POS_BITS'($urandom), pick_value());
      end
   endtask

   // drop valid, let every owed result arrive, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (due_rotations.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [DIM_SEL_BITS-1:0] sel,
                             input logic [CSR_DATA_BITS-1:0] mode);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_DIM_SELECT;
      csr_wdata <= sel;
      @(negedge clock);
      csr_index <= CSR_NEOX_MODE;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_dim_sel = sel;
      cfg_neox = mode[0];
      configs_run++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // out of reset: 128 elements, half-split pairing, no register writes yet
   task automatic test_reset_defaults();
      gaps_enable = 1'b1;
      stall_enable = 1'b1;
      send_head(7, head_dim(DIM_SEL_RESET));
   endtask

   // hand-picked extremes: saturation both ways, rounding ties, zero and
   // unit coefficients; interleaved 32-element head on the top row
   task automatic test_corner_values();
      int unsigned base;
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      set_config(DIM_SEL_32, MODE_INTERLEAVED);
      base = 255 * 32;
      for (int unsigned h = 0; h < 16; h++) begin
         send_table_write(base + h, corner_value(h));
         send_table_write(base + 16 + h, corner_value(h + 3));
      end
      for (int unsigned k = 0; k < 32; k++)
         send_element(255, (k % 2 == 0) ? corner_value(3 * (k / 2)) :
                                          corner_value(5 * (k / 2) + 2));
   endtask

   // every dimension code; the unused codes must behave as 256. The full
   // 256 head comes first so the whole pair buffer holds real data.
   task automatic test_dim_codes();
      gaps_enable = 1'b1;
      stall_enable = 1'b1;
      set_config(DIM_SEL_256, MODE_HALF_SPLIT);
      send_head(255, MAX_DIM);
      // partial heads that carry on across the unused codes
      set_config(DIM_SEL_UNUSED_5, MODE_INTERLEAVED);
      send_head(255, 40);
      set_config(DIM_SEL_UNUSED_6, MODE_INTERLEAVED);
      send_head(255, 40);
      set_config(DIM_SEL_UNUSED_7, MODE_INTERLEAVED);
      send_head(255, 40);
      // count of 120 is past 64: starts fresh
      set_config(DIM_SEL_64, MODE_HALF_SPLIT);
      send_head(128, 64);
      set_config(DIM_SEL_96, MODE_INTERLEAVED);
      send_head(254, 96);
   endtask

   // dimension and pairing changed part-way through a head
   task automatic test_mid_head_switch();
      gaps_enable = 1'b1;
      stall_enable = 1'b0;
      set_config(DIM_SEL_64, MODE_HALF_SPLIT);
      send_head(3, 40);
      set_config(DIM_SEL_32, MODE_HALF_SPLIT);   // count 40 >= 32: new head
      send_head(4, 32);
      send_head(5, 10);
      set_config(DIM_SEL_64, MODE_HALF_SPLIT);   // count 10 < 64: carries on
      send_head(5, 54);
      set_config(DIM_SEL_32, MODE_INTERLEAVED);
      send_head(6, 7);
      set_config(DIM_SEL_32, MODE_HALF_SPLIT);   // pairing flips mid-head
      send_head(6, 25);
   endtask

   // receiver holds off long enough for the result queue to fill and the
   // block to push back on a sender that keeps offering items
   task automatic test_backpressure();
      set_config(DIM_SEL_32, MODE_HALF_SPLIT);
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      @(posedge clock);
      hold_cycles = 80;
      @(negedge clock);
      send_head(0, 32);
      send_head(1, 32);
   endtask

   // Random configurations, mostly whole heads at small dimensions, with
   // stray table writes and the odd head broken off before its end.
   task automatic test_random_traffic(input int unsigned budget);
      int unsigned start;
      int unsigned dim;
      int unsigned len;
      logic [DIM_SEL_BITS-1:0] sel;
      start = elements_sent;
      noise_writes = 1'b1;
      while (elements_sent - start < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: sel = DIM_SEL_32;
            5, 6:          sel = DIM_SEL_64;
            7:             sel = DIM_SEL_96;
            8:             sel = DIM_SEL_128;
            default:       sel = $urandom_range(DIM_SEL_256, DIM_SEL_UNUSED_7);
         endcase
         gaps_enable = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         set_config(sel, ($urandom_range(0, 1) == 1) ? MODE_HALF_SPLIT : MODE_INTERLEAVED);
         dim = head_dim(sel);
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, dim - 1) : dim;
            send_head(row_pool[$urandom_range(0, 7)], len);
         end
      end
      noise_writes = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset once, then the tests in turn
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_corner_values();
      test_dim_codes();
      test_mid_head_switch();
      test_backpressure();
      test_random_traffic(600);

      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      settle();

      $display("Run covered %0d head elements and %0d table words over %0d settings;",
               elements_sent, writes_sent, configs_run);
      $display("%0d rotated results compared, input pushed back for %0d cycles.",
               results_checked, input_held);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
